@@ rtl/skg_pkg.sv @@
// skg_pkg: constants shared by the scalar kalman gyro filter
// field widths, fixed-point formats, register indexes and reset values
// no dependencies
`default_nettype none

package skg_pkg;

  localparam int unsigned AXIS_COUNT = 3;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned SAMPLE_W   = 16;

  localparam int unsigned FRAC_P     = 24;
  localparam int unsigned FRAC_X     = 16;
  localparam int unsigned COV_W      = 25;
  localparam int unsigned EST_W      = 32;
  localparam int unsigned DEN_W      = COV_W + 1;
  localparam int unsigned REM_W      = DEN_W + 1;
  localparam int unsigned GAIN_W     = FRAC_P + 1;
  localparam int unsigned DIFF_W     = EST_W + 1;
  localparam int unsigned MUL_W      = 26;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned ACC_W      = 58;
  localparam int unsigned DELTA_W    = ACC_W - FRAC_P;

  // quotient bits of the gain, one per divider step
  localparam int unsigned DIV_STEPS  = GAIN_W;
  localparam int unsigned CNT_W      = 5;

  localparam logic [COV_W-1:0]  GAIN_ONE  = COV_W'(1) << FRAC_P;
  localparam logic [COV_W-1:0]  NOISE_RST = 25'd335544;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PROCESS_NOISE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEASURE_NOISE = 1'b1;

endpackage

`default_nettype wire

@@ rtl/scalar_kalman_gyro_filter.sv @@
// scalar_kalman_gyro_filter: one-dimensional kalman filter per gyro axis
// a result passes through 1 predict step, 25 restoring divider steps for the
// gain, 3 steps on the shared multiplier and 1 rounding step
// new items are taken only in idle, after the last result reaches the output
// reset: estimates and covariances cleared, both noise registers to 335544
// depends on skg_pkg
`default_nettype none

module scalar_kalman_gyro_filter (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration write port
  input  wire logic                                   cfg_we_i,
  input  wire logic [skg_pkg::CFG_ADDR_W-1:0]         cfg_addr_i,
  input  wire logic [skg_pkg::COV_W-1:0]              cfg_wdata_i,
  // input stream
  input  wire logic                                   s_axis_tvalid,
  output      logic                                   s_axis_tready,
  input  wire logic [skg_pkg::SAMPLE_W-1:0]           s_axis_tdata,  // sample
  input  wire logic [skg_pkg::AXIS_W-1:0]             s_axis_tuser,  // axis
  // output stream
  output      logic                                   m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  output      logic [skg_pkg::SAMPLE_W-1:0]           m_axis_tdata,  // estimate
  output      logic [skg_pkg::AXIS_W-1:0]             m_axis_tuser   // axis_out
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL0 = 3'd3;
  localparam logic [2:0] ST_MUL1 = 3'd4;
  localparam logic [2:0] ST_MUL2 = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam int unsigned CW = skg_pkg::COV_W;
  localparam int unsigned EW = skg_pkg::EST_W;

  logic [2:0]                         state_q, state_d;
  logic [skg_pkg::CNT_W-1:0]          cnt_q, cnt_d;

  logic [CW-1:0]                      pnoise_q, rnoise_q;
  logic signed [EW-1:0]               est_arr_q [skg_pkg::AXIS_COUNT];
  logic [CW-1:0]                      cov_arr_q [skg_pkg::AXIS_COUNT];

  logic [skg_pkg::SAMPLE_W-1:0]       smp_q;
  logic [skg_pkg::AXIS_W-1:0]         ax_q;
  logic                               ax_ok;
  logic [CW-1:0]                      pp_q, pp_d;
  logic [skg_pkg::DEN_W-1:0]          den_q, den_d;
  logic [skg_pkg::REM_W-1:0]          rem_q, rem_d;
  logic [skg_pkg::GAIN_W-1:0]         k_q, k_d;
  logic signed [skg_pkg::DIFF_W-1:0]  diff_q, diff_d;
  logic signed [EW-1:0]               est_q, est_d;
  logic signed [skg_pkg::ACC_W-1:0]   acc_q, acc_d;

  logic                               out_valid_q;
  logic [skg_pkg::SAMPLE_W-1:0]       out_est_q;
  logic [skg_pkg::AXIS_W-1:0]         out_ax_q;

  // combinational helpers
  logic [CW:0]                        pp_sum;
  logic [CW-1:0]                      pp_sat;
  logic [skg_pkg::REM_W-1:0]          rem_s;
  logic                               rem_ge;
  logic signed [skg_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [skg_pkg::PROD_W-1:0]  mul_p;
  logic signed [skg_pkg::ACC_W-1:0]   acc_rnd;
  logic signed [skg_pkg::DELTA_W-1:0] delta;
  logic [EW+2:0]                      est_sum;
  logic signed [EW-1:0]               est_new;
  logic [skg_pkg::PROD_W-3:0]         pn_sum;
  logic [CW-1:0]                      pn;
  logic [EW:0]                        y_sum;
  logic [skg_pkg::SAMPLE_W:0]         y_wide;
  logic [skg_pkg::SAMPLE_W-1:0]       y_sat;
  logic                               in_txn, out_free, est_we;

  assign ax_ok    = (32'(ax_q) < skg_pkg::AXIS_COUNT);
  assign in_txn   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign est_we   = (state_q == ST_MUL2);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_est_q;
  assign m_axis_tuser  = out_ax_q;

  // predicted covariance, saturated
  always_comb begin
    pp_sum = {1'b0, cov_arr_q[ax_q]} + {1'b0, pnoise_q};
    pp_sat = pp_sum[CW] ? {CW{1'b1}} : pp_sum[CW-1:0];
  end

  // one restoring divider step
  always_comb begin
    rem_s  = (cnt_q == '0) ? rem_q : {rem_q[skg_pkg::REM_W-2:0], 1'b0};
    rem_ge = (rem_s >= {1'b0, den_q});
  end

  // shared multiplier operands
  always_comb begin
    unique case (state_q)
      ST_MUL0: begin
        mul_a = {1'b0, k_q};
        mul_b = {10'b0, diff_q[15:0]};
      end
      ST_MUL1: begin
        mul_a = {1'b0, k_q};
        mul_b = {{9{diff_q[skg_pkg::DIFF_W-1]}}, diff_q[skg_pkg::DIFF_W-1:16]};
      end
      ST_MUL2: begin
        mul_a = {1'b0, skg_pkg::GAIN_ONE - k_q};
        mul_b = {1'b0, pp_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // estimate and covariance update, output rounding
  always_comb begin
    acc_rnd = acc_q + (skg_pkg::ACC_W'(1) <<< (skg_pkg::FRAC_P - 1));
    delta   = acc_rnd[skg_pkg::ACC_W-1:skg_pkg::FRAC_P];
    est_sum = {{3{est_q[EW-1]}}, est_q} + {delta[skg_pkg::DELTA_W-1], delta};
    if (est_sum[EW+2:EW-1] == 4'b0000 || est_sum[EW+2:EW-1] == 4'b1111) begin
      est_new = est_sum[EW-1:0];
    end else if (est_sum[EW+2]) begin
      est_new = {1'b1, {(EW-1){1'b0}}};
    end else begin
      est_new = {1'b0, {(EW-1){1'b1}}};
    end

    // product is nonnegative here
    pn_sum = mul_p[skg_pkg::PROD_W-3:0]
           + ((skg_pkg::PROD_W-2)'(1) << (skg_pkg::FRAC_P - 1));
    pn     = pn_sum[skg_pkg::PROD_W-3] ? {CW{1'b1}}
                                       : pn_sum[skg_pkg::FRAC_P+CW-1:skg_pkg::FRAC_P];

    y_sum  = {est_q[EW-1], est_q} + ((EW+1)'(1) << (skg_pkg::FRAC_X - 1));
    y_wide = y_sum[EW:skg_pkg::FRAC_X];
    if (y_wide[skg_pkg::SAMPLE_W] == y_wide[skg_pkg::SAMPLE_W-1]) begin
      y_sat = y_wide[skg_pkg::SAMPLE_W-1:0];
    end else if (y_wide[skg_pkg::SAMPLE_W]) begin
      y_sat = {1'b1, {(skg_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(skg_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pp_d    = pp_q;
    den_d   = den_q;
    rem_d   = rem_q;
    k_d     = k_q;
    diff_d  = diff_q;
    est_d   = est_q;
    acc_d   = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_txn) begin
          est_d   = '0;
          state_d = (32'(s_axis_tuser) < skg_pkg::AXIS_COUNT) ? ST_PRED : ST_FIN;
        end
      end
      ST_PRED: begin
        pp_d    = pp_sat;
        den_d   = {1'b0, pp_sat} + {1'b0, rnoise_q};
        rem_d   = {2'b00, pp_sat};
        k_d     = '0;
        cnt_d   = '0;
        est_d   = est_arr_q[ax_q];
        diff_d  = {smp_q[skg_pkg::SAMPLE_W-1], smp_q, 16'b0}
                - {est_arr_q[ax_q][EW-1], est_arr_q[ax_q]};
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = rem_ge ? rem_s - {1'b0, den_q} : rem_s;
        k_d   = {k_q[skg_pkg::GAIN_W-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == skg_pkg::DIV_STEPS - 1) begin
          // zero denominator means zero gain
          if (den_q == '0) begin
            k_d = '0;
          end
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: begin
        acc_d   = skg_pkg::ACC_W'(mul_p);
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc_d   = acc_q + (skg_pkg::ACC_W'(mul_p) <<< 16);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        est_d   = est_new;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pnoise_q    <= skg_pkg::NOISE_RST;
      rnoise_q    <= skg_pkg::NOISE_RST;
      for (int i = 0; i < skg_pkg::AXIS_COUNT; i++) begin
        est_arr_q[i] <= '0;
        cov_arr_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == skg_pkg::CFG_PROCESS_NOISE) begin
          pnoise_q <= cfg_wdata_i;
        end
        if (cfg_addr_i == skg_pkg::CFG_MEASURE_NOISE) begin
          rnoise_q <= cfg_wdata_i;
        end
      end
      if (est_we) begin
        est_arr_q[ax_q] <= est_new;
        cov_arr_q[ax_q] <= pn;
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pp_q   <= pp_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    k_q    <= k_d;
    diff_q <= diff_d;
    est_q  <= est_d;
    acc_q  <= acc_d;
    if (in_txn) begin
      smp_q <= s_axis_tdata;
      ax_q  <= s_axis_tuser;
    end
    if (state_q == ST_FIN && out_free) begin
      out_est_q <= y_sat;
      out_ax_q  <= ax_q;
    end
  end

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // divider step count stays within the quotient width
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (32'(cnt_q) < skg_pkg::DIV_STEPS))
    else $error("divider step count overran");

  // gain never exceeds one
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL0) |-> (k_q <= skg_pkg::GAIN_ONE))
    else $error("kalman gain above one");

  // an axis out of range gives a zero result
  a_bad_axis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !ax_ok) |-> (est_q == '0))
    else $error("out of range axis produced a nonzero estimate");

endmodule

`default_nettype wire
